### rtl/ibt_pkg.sv
// ----------------------------------------------------------------------------
// ibt_pkg
// Shared types and constants of the interval booking table.
// ----------------------------------------------------------------------------
package ibt_pkg;

   localparam int TIME_W   = 32;
   localparam int HELD_W   = 7;

   typedef enum logic [1:0] {
      STATUS_BOOKED  = 2'd0,
      STATUS_OVERLAP = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   // request broadcast from the controller to every cell
   typedef struct packed {
      logic              capture;
      logic              commit;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
   } bcast_type;

   // table summary returned to the controller
   typedef struct packed {
      logic clash;
      logic full;
   } stat_type;

endpackage

### rtl/ibt_if.sv
// ----------------------------------------------------------------------------
// ibt_req_if / ibt_rsp_if
// Valid/ready channels for booking requests and their responses.
// ----------------------------------------------------------------------------
interface ibt_req_if;
   logic                      valid;
   logic                      ready;
   logic [ibt_pkg::TIME_W-1:0] start_time;
   logic [ibt_pkg::TIME_W-1:0] end_time;

   modport source (output valid, output start_time, output end_time, input ready);
   modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

interface ibt_rsp_if;
   logic                       valid;
   logic                       ready;
   ibt_pkg::status_type        status;
   logic [ibt_pkg::HELD_W-1:0] bookings_held;

   modport source (output valid, output status, output bookings_held, input ready);
   modport sink   (input valid, input status, input bookings_held, output ready);
endinterface

### rtl/ibt_cell.sv
// ----------------------------------------------------------------------------
// ibt_cell
// One table slot: holds an interval, flags overlap with a captured request,
// and fills itself when its lower neighbor is occupied and it is not.
// ----------------------------------------------------------------------------
module ibt_cell #(
   parameter int CMP_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  ibt_pkg::bcast_type bus,
   input  logic               prev_valid,
   output logic               valid,
   output logic               hit
);

   logic                valid_ff;
   logic                valid_in;
   logic                hit_ff;
   logic                hit_in;
   logic [CMP_BITS-1:0] start_ff;
   logic [CMP_BITS-1:0] end_ff;
   logic [CMP_BITS-1:0] req_start;
   logic [CMP_BITS-1:0] req_end;
   logic                write_en;

   assign req_start = bus.start_time[CMP_BITS-1:0];
   assign req_end   = bus.end_time[CMP_BITS-1:0];
   assign write_en  = bus.commit && !valid_ff && prev_valid;

   always_comb begin
      valid_in = valid_ff || write_en;
      hit_in   = hit_ff;
      if (bus.capture) begin
         hit_in = valid_ff && (start_ff < req_end) && (end_ff > req_start);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         start_ff <= req_start;
         end_ff   <= req_end;
      end
   end

   assign valid = valid_ff;
   assign hit   = hit_ff;

endmodule

### rtl/ibt_ctrl.sv
// ----------------------------------------------------------------------------
// ibt_ctrl
// Request sequencer: captures a request, resolves status from the cell
// summary, commits bookings and holds the response register.
// ----------------------------------------------------------------------------
module ibt_ctrl #(
   parameter int CMP_BITS = 32,
   parameter int CNT_W    = 7
) (
   input  logic               clock,
   input  logic               reset,
   ibt_req_if.sink            req,
   ibt_rsp_if.source          rsp,
   input  ibt_pkg::stat_type  stat,
   output ibt_pkg::bcast_type bus,
   output logic [CNT_W-1:0]   held
);

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } state_type;

   state_type                  state_ff;
   logic [ibt_pkg::TIME_W-1:0] start_ff;
   logic [ibt_pkg::TIME_W-1:0] end_ff;
   logic                       invalid_ff;
   logic                       invalid_in;
   logic [CNT_W-1:0]           held_cnt_ff;
   logic [CNT_W-1:0]           held_cnt_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   ibt_pkg::status_type        status_ff;
   ibt_pkg::status_type        status_in;
   logic [ibt_pkg::HELD_W-1:0] held_out_ff;
   logic                       capture;
   logic                       out_free;
   logic                       load;
   logic                       commit;

   assign req.ready = (state_ff == ST_IDLE);
   assign capture   = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign load      = (state_ff == ST_EVAL) && out_free;
   assign invalid_in = req.start_time[CMP_BITS-1:0] >= req.end_time[CMP_BITS-1:0];
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);

   always_comb begin
      priority if (invalid_ff) begin
         status_in = ibt_pkg::STATUS_INVALID;
      end else if (stat.clash) begin
         status_in = ibt_pkg::STATUS_OVERLAP;
      end else if (stat.full) begin
         status_in = ibt_pkg::STATUS_FULL;
      end else begin
         status_in = ibt_pkg::STATUS_BOOKED;
      end
   end

   assign commit      = load && (status_in == ibt_pkg::STATUS_BOOKED);
   assign held_cnt_in = commit ? held_cnt_ff + 1'b1 : held_cnt_ff;

   always_comb begin
      bus.capture = capture;
      bus.commit  = commit;
      if (state_ff == ST_IDLE) begin
         bus.start_time = req.start_time;
         bus.end_time   = req.end_time;
      end else begin
         bus.start_time = start_ff;
         bus.end_time   = end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         held_cnt_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (capture) begin
                  start_ff   <= req.start_time;
                  end_ff     <= req.end_time;
                  invalid_ff <= invalid_in;
                  state_ff   <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               if (load) begin
                  status_ff    <= status_in;
                  held_out_ff  <= ibt_pkg::HELD_W'(held_cnt_in);
                  held_cnt_ff  <= held_cnt_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.bookings_held = held_out_ff;
   assign held              = held_cnt_ff;

`ifndef SYNTHESIS
   a_commit_clean: assert property (@(posedge clock) disable iff (reset)
      commit |-> !stat.full && !stat.clash && !invalid_ff)
      else $error("booking committed into a full or conflicting table");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      commit |=> held_cnt_ff == $past(held_cnt_ff) + 1'b1)
      else $error("held count did not advance on booking");

   a_capture_eval: assert property (@(posedge clock) disable iff (reset)
      capture |=> state_ff == ST_EVAL && !req.ready)
      else $error("captured request not evaluated");
`endif

endmodule

### rtl/interval_booking_table_top.sv
// ----------------------------------------------------------------------------
// interval_booking_table_top
// Non-overlapping interval reservation table built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each request reserves [start_time, end_time) and gets one response: booked,
// overlap, table full or invalid (start at or after end), plus the number of
// bookings held afterwards. When a request is accepted, every cell compares
// it against its stored interval and registers a hit flag; then, once the
// output register is free, the hit flags are combined, the status is
// resolved and a booking is written into the lowest free cell. Cells fill in
// order, so each cell decides from its lower neighbor whether it is next.
// The response sits in an output register; a new request is taken once the
// previous one has been resolved. Times are compared at TIME_BITS bits, at
// most 32.
module interval_booking_table_top #(
   parameter int ENTRIES   = 64,
   parameter int TIME_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   ibt_req_if.sink   req,
   ibt_rsp_if.source rsp
);

   localparam int CMP_BITS = (TIME_BITS < ibt_pkg::TIME_W) ? TIME_BITS : ibt_pkg::TIME_W;
   localparam int CNT_W    = $clog2(ENTRIES + 1);

   ibt_pkg::bcast_type bus;
   ibt_pkg::stat_type  stat;
   logic [ENTRIES-1:0] valid_vec;
   logic [ENTRIES-1:0] hit_vec;
   logic [CNT_W-1:0]   held;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic prev_valid;
      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = valid_vec[i-1];
      end
      ibt_cell #(
         .CMP_BITS (CMP_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .bus        (bus),
         .prev_valid (prev_valid),
         .valid      (valid_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   assign stat.clash = |hit_vec;
   assign stat.full  = valid_vec[ENTRIES-1];

   ibt_ctrl #(
      .CMP_BITS (CMP_BITS),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .stat  (stat),
      .bus   (bus),
      .held  (held)
   );

`ifndef SYNTHESIS
   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("cells not filled in order");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(held))
      else $error("held count disagrees with occupied cells");

   a_single_fill: assert property (@(posedge clock) disable iff (reset)
      bus.commit |=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
      else $error("booking did not fill exactly one cell");
`endif

endmodule
